// ===== hw/rtl/rsch_pkg.sv =====
// shared types and constants for the ray-sphere closest-hit block
package rsch_pkg;

	localparam int MAX_SPHERES = 16;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 5;
	localparam int RAD_W       = 47;
	localparam int CRD_W       = 48;
	localparam int DIR_W       = 32;
	localparam int OP_W        = CRD_W + 1;
	localparam int MAG_W       = 53;
	localparam int SEL_W       = MAG_W + 1;
	localparam int PROD_W      = 2 * MAG_W;
	localparam int ACC_W       = 110;
	localparam int B_W         = 54;
	localparam int REM_W       = MAG_W + 4;
	localparam int DIST_W      = 55;
	localparam int STEP_W      = 6;
	localparam int EPS_FIX     = 6;
	localparam int B_SHIFT     = 30;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic                    func;
		logic [IDX_W-1:0]        entry_index;
		logic [RAD_W-1:0]        radius;
		logic signed [CRD_W-1:0] center_x;
		logic signed [CRD_W-1:0] center_y;
		logic signed [CRD_W-1:0] center_z;
		logic signed [CRD_W-1:0] origin_x;
		logic signed [CRD_W-1:0] origin_y;
		logic signed [CRD_W-1:0] origin_z;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
	} in_item_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_index;
		logic [RAD_W-1:0] distance;
	} out_item_t;

	typedef struct packed {
		logic     is_query;
		in_item_t item;
	} q_item_t;

endpackage

// ===== hw/rtl/ray_sphere_closest_hit.sv =====
// Ray-sphere closest-hit unit. Load items write one of 16 sphere entries;
// queries test entries min(sphere_count, 16)-1 down to 0. Each tested
// sphere runs all eight products through the one bit-per-cycle shift-add
// multiplier, then the one bit-per-cycle square root; the square root is
// skipped when the discriminant is negative. A two-entry queue sits between
// input and back end, and a result register lets the back end finish while the
// output is stalled. Write sphere_count only while the block is idle.
module ray_sphere_closest_hit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rsch_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rsch_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rsch_pkg::out_item_t         out_data
);
	import rsch_pkg::*;

	logic              q_valid;
	logic              q_ready;
	q_item_t           q_data;
	logic [QCNT_W-1:0] fill;

	rsch_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data),
		.fill     (fill)
	);

	rsch_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= QCNT_W'(QDEPTH)) else $error("queue overfilled");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		fill == QCNT_W'(QDEPTH) |-> !in_ready) else $error("transfer into full queue");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.hit_index == '0 && out_data.distance == '0)
		else $error("miss result not zero");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !(q_valid && q_ready) |=> fill == $past(fill) + 1'b1)
		else $error("queue count lost a transfer");
`endif

endmodule

// ===== hw/rtl/rsch_front.sv =====
// input side: accepts items, tags queries and loads, queues them for the back end
module rsch_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rsch_pkg::in_item_t                in_data,
	output logic                              q_valid,
	input  logic                              q_ready,
	output rsch_pkg::q_item_t                 q_data,
	output logic [rsch_pkg::QCNT_W-1:0]       fill
);
	import rsch_pkg::*;

	q_item_t           slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign in_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_data   = slot_q[rd_ptr_q];
	assign fill     = cnt_q;
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].is_query <= (in_data.func == FUNC_QUERY);
			slot_q[wr_ptr_q].item     <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/rsch_back.sv =====
// execution side: sphere table, serial multiplier, serial square root, nearest-hit search
module rsch_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rsch_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  rsch_pkg::q_item_t             q_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rsch_pkg::out_item_t           out_data
);
	import rsch_pkg::*;

	typedef struct packed {
		logic [RAD_W-1:0]        radius;
		logic signed [CRD_W-1:0] cx;
		logic signed [CRD_W-1:0] cy;
		logic signed [CRD_W-1:0] cz;
	} sphere_t;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RD     = 4'd1;
	localparam logic [3:0] S_OP     = 4'd2;
	localparam logic [3:0] S_MSTART = 4'd3;
	localparam logic [3:0] S_MRUN   = 4'd4;
	localparam logic [3:0] S_MACC   = 4'd5;
	localparam logic [3:0] S_BCALC  = 4'd6;
	localparam logic [3:0] S_SQINIT = 4'd7;
	localparam logic [3:0] S_SQRUN  = 4'd8;
	localparam logic [3:0] S_DIST   = 4'd9;
	localparam logic [3:0] S_NEXT   = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	localparam logic [2:0] J_LAST_DOT = 3'd5;
	localparam logic [2:0] J_LAST     = 3'd7;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAG_W - 1);
	localparam logic signed [ACC_W-1:0]  RND = ACC_W'(1) << (B_SHIFT - 1);
	localparam logic signed [DIST_W-1:0] EPS = DIST_W'(EPS_FIX);
	localparam logic signed [DIST_W-1:0] SAT = (DIST_W'(1) << RAD_W) - DIST_W'(1);

	sphere_t                  mem [MAX_SPHERES];
	sphere_t                  rd_q;
	logic [3:0]               state_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [CRD_W-1:0]  org_q [3];
	logic signed [DIR_W-1:0]  dir_q [3];
	logic signed [OP_W-1:0]   op_q [3];
	logic [IDX_W-1:0]         k_q;
	logic [2:0]               j_q;
	logic [PROD_W-1:0]        ma_q;
	logic [MAG_W-1:0]         mb_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     neg_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [ACC_W-1:0]  raw_q;
	logic signed [ACC_W-1:0]  det_q;
	logic signed [B_W-1:0]    b_q;
	logic [PROD_W-1:0]        rad_q;
	logic [REM_W-1:0]         rem_q;
	logic [MAG_W-1:0]         root_q;
	logic                     found_q;
	logic signed [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic                     pop;
	logic                     out_free;
	logic [CNT_W-1:0]         n_eff;
	logic signed [SEL_W-1:0]  sel_a;
	logic signed [SEL_W-1:0]  sel_b;
	logic [MAG_W-1:0]         mag_a;
	logic [MAG_W-1:0]         mag_b;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  rnd_sum;
	logic [REM_W-1:0]         rem_x;
	logic [REM_W-1:0]         trial;
	logic signed [DIST_W-1:0] t_lo;
	logic signed [DIST_W-1:0] t_hi;
	logic                     cand;
	logic signed [DIST_W-1:0] d_cand;

	assign q_ready   = (state_q == S_IDLE);
	assign pop       = q_valid && q_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign n_eff     = (count_q > CNT_W'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES) : count_q;

	always_comb begin
		case (j_q)
			3'd0: begin sel_a = SEL_W'(op_q[0]); sel_b = SEL_W'(dir_q[0]); end
			3'd1: begin sel_a = SEL_W'(op_q[1]); sel_b = SEL_W'(dir_q[1]); end
			3'd2: begin sel_a = SEL_W'(op_q[2]); sel_b = SEL_W'(dir_q[2]); end
			3'd3: begin sel_a = SEL_W'(op_q[0]); sel_b = SEL_W'(op_q[0]); end
			3'd4: begin sel_a = SEL_W'(op_q[1]); sel_b = SEL_W'(op_q[1]); end
			3'd5: begin sel_a = SEL_W'(op_q[2]); sel_b = SEL_W'(op_q[2]); end
			3'd6: begin sel_a = SEL_W'(b_q); sel_b = SEL_W'(b_q); end
			default: begin
				sel_a = SEL_W'(rd_q.radius);
				sel_b = SEL_W'(rd_q.radius);
			end
		endcase
		mag_a   = sel_a[SEL_W-1] ? MAG_W'(-sel_a) : MAG_W'(sel_a);
		mag_b   = sel_b[SEL_W-1] ? MAG_W'(-sel_b) : MAG_W'(sel_b);
		prod_x  = neg_q ? -ACC_W'(prod_q) : ACC_W'(prod_q);
		rnd_sum = raw_q + RND;
		rem_x   = {rem_q[REM_W-3:0], rad_q[PROD_W-1 -: 2]};
		trial   = REM_W'({root_q, 2'b01});
		t_lo    = DIST_W'(b_q) - DIST_W'(root_q);
		t_hi    = DIST_W'(b_q) + DIST_W'(root_q);
		cand    = (t_lo > EPS) || (t_hi > EPS);
		d_cand  = (t_lo > EPS) ? t_lo : t_hi;
	end

	// sphere table
	always_ff @(posedge clk) begin
		if (pop && !q_data.is_query) begin
			mem[q_data.item.entry_index] <= '{radius: q_data.item.radius,
				cx: q_data.item.center_x, cy: q_data.item.center_y,
				cz: q_data.item.center_z};
		end
		rd_q <= mem[k_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop && q_data.is_query) begin
					org_q[0] <= q_data.item.origin_x;
					org_q[1] <= q_data.item.origin_y;
					org_q[2] <= q_data.item.origin_z;
					dir_q[0] <= q_data.item.dir_x;
					dir_q[1] <= q_data.item.dir_y;
					dir_q[2] <= q_data.item.dir_z;
					best_q     <= '0;
					best_idx_q <= '0;
				end
			end
			S_OP: begin
				op_q[0] <= OP_W'(rd_q.cx) - OP_W'(org_q[0]);
				op_q[1] <= OP_W'(rd_q.cy) - OP_W'(org_q[1]);
				op_q[2] <= OP_W'(rd_q.cz) - OP_W'(org_q[2]);
				raw_q   <= '0;
				det_q   <= '0;
			end
			S_MSTART: begin
				ma_q   <= PROD_W'(mag_a);
				mb_q   <= mag_b;
				prod_q <= '0;
				neg_q  <= sel_a[SEL_W-1] ^ sel_b[SEL_W-1];
			end
			S_MRUN: begin
				if (mb_q[0]) prod_q <= prod_q + ma_q;
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end
			S_MACC: begin
				if (j_q < 3'd3) raw_q <= raw_q + prod_x;
				else if (j_q <= J_LAST_DOT) det_q <= det_q - prod_x;
				else det_q <= det_q + prod_x;
			end
			S_BCALC: b_q <= B_W'(rnd_sum >>> B_SHIFT);
			S_SQINIT: begin
				rad_q  <= det_q[PROD_W-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			S_SQRUN: begin
				rad_q <= rad_q << 2;
				if (rem_x >= trial) begin
					rem_q  <= rem_x - trial;
					root_q <= {root_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_x;
					root_q <= {root_q[MAG_W-2:0], 1'b0};
				end
			end
			S_DIST: begin
				if (cand && (!found_q || d_cand < best_q)) begin
					best_q     <= d_cand;
					best_idx_q <= k_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			j_q         <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop && q_data.is_query) begin
						found_q <= 1'b0;
						if (n_eff == '0) begin
							state_q <= S_OUT;
						end else begin
							k_q     <= IDX_W'(n_eff - 1'b1);
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_OP;
				S_OP: begin
					j_q     <= '0;
					state_q <= S_MSTART;
				end
				S_MSTART: begin
					step_q  <= '0;
					state_q <= S_MRUN;
				end
				S_MRUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) state_q <= S_MACC;
				end
				S_MACC: begin
					j_q <= j_q + 1'b1;
					if (j_q == J_LAST) state_q <= S_SQINIT;
					else if (j_q == J_LAST_DOT) state_q <= S_BCALC;
					else state_q <= S_MSTART;
				end
				S_BCALC: state_q <= S_MSTART;
				S_SQINIT: begin
					step_q  <= '0;
					state_q <= det_q[ACC_W-1] ? S_NEXT : S_SQRUN;
				end
				S_SQRUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) state_q <= S_DIST;
				end
				S_DIST: begin
					if (cand) found_q <= 1'b1;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (k_q == '0) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= k_q - 1'b1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_q.hit       <= found_q;
			out_q.hit_index <= found_q ? best_idx_q : '0;
			if (!found_q) out_q.distance <= '0;
			else if (best_q > SAT) out_q.distance <= RAD_W'(SAT);
			else out_q.distance <= RAD_W'(best_q);
		end
	end

endmodule
